// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the command unpacker RTL. The
// checks are compiled for simulation and drop out in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never hold outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/pcu_pkg.sv
// ----------------------------------------------------------------------------
// Command unpacker package
// Widths, request codes and the control and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcu_pkg;

    localparam int CMD_W             = 8;
    localparam int WORD_W            = 32;
    localparam int CNT_W             = 6;
    localparam int REQ_W             = 2;
    localparam int TABLE_DEPTH       = 256;
    localparam int TBL_AW            = $clog2(TABLE_DEPTH);
    localparam int COMMANDS_PER_WORD = 4;
    localparam int LEFT_W            = $clog2(COMMANDS_PER_WORD + 1);

    typedef logic [CMD_W-1:0]  t_cmd_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [TBL_AW-1:0] t_tbl_addr;
    typedef logic [LEFT_W-1:0] t_left;

    // Request kinds.
    localparam t_req REQ_PACKED = 2'd0;
    localparam t_req REQ_DIRECT = 2'd1;
    localparam t_req REQ_LOAD   = 2'd2;

    // Command numbers that have a direct-port address.
    localparam t_cmd_byte DIRECT_FIRST = 8'h10;
    localparam t_cmd_byte DIRECT_LAST  = 8'h72;

    localparam t_left LEFT_FULL = LEFT_W'(COMMANDS_PER_WORD);

    // Controller to datapath.
    typedef struct packed {
        logic tbl_write;    // write the count table from the input fields
        logic start_word;   // open a new packed word
        logic next_param;   // parameter word for the current command
        logic direct_load;  // stage a direct-port entry
        logic look;         // read the table at the current command byte
        logic load_needed;  // latch the table read as the parameter count
        logic emit;         // stage an entry for the current command byte
        logic shift;        // retire the current command byte
        logic flush;        // hand the staged entry out as the last one
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic geom_en;
        logic direct_ok;
        logic left_zero;
        logic left_one;
        logic emit_cond;
        logic seen_ge_needed;
        logic count_nonzero;
        logic pend_valid;
        logic slot_free;
    } t_dp_status;

endpackage

// File: rtl/pcu_count_table.sv
// ----------------------------------------------------------------------------
// Parameter count table
// 256-entry memory of parameter counts with a valid bit per entry, so that
// entries never written since reset read as zero. Read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcu_count_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  pcu_pkg::t_tbl_addr i_wr_addr,
    input  pcu_pkg::t_count    i_wr_data,
    input  logic               i_rd_en,
    input  pcu_pkg::t_tbl_addr i_rd_addr,
    output pcu_pkg::t_count    o_rd_count
);
    import pcu_pkg::*;

    t_count                 r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_vld;
    t_count                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_count = r_rd_vld ? r_rd_data : '0;

endmodule

// File: rtl/pcu_ctrl.sv
// ----------------------------------------------------------------------------
// Command unpacker controller
// Sequences table lookups, entry staging and hand-off for each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pcu_pkg::t_req       i_req_type,
    input  pcu_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output pcu_pkg::t_dp_cmd    o_cmd
);
    import pcu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ITER  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        REQ_LOAD: begin
                            o_cmd.tbl_write = 1'b1;
                        end
                        REQ_PACKED: begin
                            if (i_status.geom_en) begin
                                if (i_status.left_zero) begin
                                    o_cmd.start_word = 1'b1;
                                    n_state          = S_LOOK;
                                end else begin
                                    o_cmd.next_param = 1'b1;
                                    n_state          = S_ITER;
                                end
                            end
                        end
                        REQ_DIRECT: begin
                            if (i_status.geom_en && i_status.direct_ok) begin
                                o_cmd.direct_load = 1'b1;
                                n_state           = S_FLUSH;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // A command that needs parameters waits for the next words.
                o_cmd.load_needed = 1'b1;
                n_state           = i_status.count_nonzero ? S_FLUSH : S_ITER;
            end
            S_ITER: begin
                if (!(i_status.emit_cond && i_status.pend_valid && !i_status.slot_free)) begin
                    o_cmd.emit = i_status.emit_cond;
                    if (i_status.seen_ge_needed) begin
                        o_cmd.shift = 1'b1;
                        n_state     = i_status.left_one ? S_FLUSH : S_LOOK;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/pcu_datapath.sv
// ----------------------------------------------------------------------------
// Command unpacker datapath
// Holds the packed word, the parameter bookkeeping, the staged entry, the
// output register, the enable register and the count table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcu_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcu_pkg::t_dp_cmd    i_cmd,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_data,
    input  pcu_pkg::t_cmd_byte  i_command_index,
    input  pcu_pkg::t_word      i_word,
    input  pcu_pkg::t_count     i_param_count,
    input  logic                i_out_ready,
    output pcu_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output pcu_pkg::t_cmd_byte  o_command,
    output pcu_pkg::t_word      o_param,
    output logic                o_last
);
    import pcu_pkg::*;

    logic      r_geom_en;
    t_word     r_word;
    t_word     r_val;
    t_left     r_left;
    t_count    r_seen;
    t_count    r_needed;
    logic      r_pend_valid;
    t_cmd_byte r_pend_cmd;
    t_word     r_pend_param;
    logic      r_out_valid;
    t_cmd_byte r_out_cmd;
    t_word     r_out_param;
    logic      r_out_last;

    t_count    w_rd_count;
    logic      w_push;
    logic      w_direct_ok;

    pcu_count_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cmd.tbl_write),
        .i_wr_addr  (i_command_index),
        .i_wr_data  (i_param_count),
        .i_rd_en    (i_cmd.look),
        .i_rd_addr  (r_word[CMD_W-1:0]),
        .o_rd_count (w_rd_count)
    );

    always_comb begin
        w_direct_ok = i_command_index inside {[DIRECT_FIRST:DIRECT_LAST]};
    end

    // A new entry pushes the previously staged one out; a flush pushes it as last.
    assign w_push = (i_cmd.emit && r_pend_valid) || i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom_en    <= 1'b1;
            r_word       <= '0;
            r_left       <= '0;
            r_seen       <= '0;
            r_needed     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_geom_en <= i_cfg_data;
            end
            if (i_cmd.start_word) begin
                r_word <= i_word;
                r_left <= LEFT_FULL;
                r_seen <= '0;
            end else if (i_cmd.next_param) begin
                r_seen <= r_seen + 1'b1;
            end else if (i_cmd.shift) begin
                r_word <= r_word >> CMD_W;
                r_left <= r_left - 1'b1;
                r_seen <= '0;
            end
            if (i_cmd.load_needed) begin
                r_needed <= w_rd_count;
            end
            if (i_cmd.direct_load || i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_word || i_cmd.next_param) begin
            r_val <= i_word;
        end
        if (i_cmd.direct_load) begin
            r_pend_cmd   <= i_command_index;
            r_pend_param <= i_word;
        end else if (i_cmd.emit) begin
            r_pend_cmd   <= r_word[CMD_W-1:0];
            r_pend_param <= r_val;
        end
        if (w_push) begin
            r_out_cmd   <= r_pend_cmd;
            r_out_param <= r_pend_param;
            r_out_last  <= i_cmd.flush;
        end
    end

    always_comb begin
        o_status.geom_en        = r_geom_en;
        o_status.direct_ok      = w_direct_ok;
        o_status.left_zero      = (r_left == '0);
        o_status.left_one       = (r_left == t_left'(1));
        o_status.emit_cond      = (r_word[CMD_W-1:0] != '0)
                                  || ((r_left == LEFT_FULL) && (r_word == '0));
        o_status.seen_ge_needed = (r_seen >= r_needed);
        o_status.count_nonzero  = (w_rd_count != '0);
        o_status.pend_valid     = r_pend_valid;
        o_status.slot_free      = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_command   = r_out_cmd;
    assign o_param     = r_out_param;
    assign o_last      = r_out_last;

endmodule

// File: rtl/packed_command_unpacker.sv
// ----------------------------------------------------------------------------
// Packed command unpacker
// Turns packed and direct geometry command port writes into command FIFO
// entries of a command byte and a 32-bit parameter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// A packed word carries four command bytes, lowest first; each command takes
// its parameter count from a 256-entry table that is loaded through request
// kind 2 and reads as zero for entries not loaded since reset. A command with
// no parameters produces one entry at once carrying the current word; a
// command with parameters produces one entry per following parameter word.
// Zero command bytes are skipped, but an all-zero packed word gives a single
// command 0 entry. A direct-port write of command 0x10 to 0x72 gives one entry.
// Packed and direct writes are ignored while the enable register is zero.
// The o_last flag marks the final entry caused by an input transfer. A table
// load or an ignored request ends in its accept step; a direct write has an
// accept step and a closing step. A packed transfer has an accept step and a
// closing step, and between them a table lookup for each command it reaches,
// through the registered read of the count table, and the passes of the unpack
// step, which stages at most one entry and retires at most one command byte.
// A fresh word of four parameterless commands is the longest case. The staged
// entry and the output register hold two finished entries between them, so a
// waiting downstream stalls the unpacker only when both are occupied and
// another entry has to move. The enable register can be written at any time
// through the configuration channel and is never back-pressured; a write
// affects the requests accepted after it.

module packed_command_unpacker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pcu_pkg::t_req      i_req_type,
    input  pcu_pkg::t_cmd_byte i_command_index,
    input  pcu_pkg::t_word     i_word,
    input  pcu_pkg::t_count    i_param_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pcu_pkg::t_cmd_byte o_command,
    output pcu_pkg::t_word     o_param,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import pcu_pkg::*;

    `include "assert_macros.svh"

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_emit_push;
    logic       w_flush_ok;

    // The enable register accepts a configuration transfer every cycle.
    assign o_cfg_ready = 1'b1;

    pcu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    pcu_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_command_index (i_command_index),
        .i_word          (i_word),
        .i_param_count   (i_param_count),
        .i_out_ready     (i_out_ready),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_command       (o_command),
        .o_param         (o_param),
        .o_last          (o_last)
    );

    // A new entry that lands on a staged one pushes the older entry out.
    assign w_emit_push = w_cmd.emit && w_status.pend_valid;
    // A flush needs a real staged entry and a free output register.
    assign w_flush_ok  = w_status.pend_valid && w_status.slot_free;

    // Staging a new entry over a full one may only happen when the output
    // register can take the older entry.
    `ASSERT_CLK(a_emit_slot, i_clk, i_rst_n, w_emit_push |-> w_status.slot_free, "emit blocked")

    // A flush always moves a real staged entry into a free output register.
    `ASSERT_CLK(a_flush_ok, i_clk, i_rst_n, w_cmd.flush |-> w_flush_ok, "bad flush")

    // Every input transfer finishes with its staged entry handed out.
    `ASSERT_NEVER(a_idle_clean, i_clk, i_rst_n, o_in_ready && w_status.pend_valid, "stale entry")

endmodule
